[rtl/kdlp_pkg.sv]
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce and long-press unit.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int unsigned NOW_W   = 32;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

    typedef enum logic [CIDX_W-1:0] {
        REG_ACTIVE_LOW = 2'd0,
        REG_DEBOUNCE   = 2'd1,
        REG_LONG_PRESS = 2'd2,
        REG_REPEAT     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             active_low;
        logic [THR_W-1:0] debounce_ticks;
        logic [THR_W-1:0] long_press_ticks;
        logic [THR_W-1:0] repeat_ticks;
    } t_cfg;

    localparam logic [THR_W-1:0] RST_DEBOUNCE   = 16'd20;
    localparam logic [THR_W-1:0] RST_LONG_PRESS = 16'd1000;
    localparam logic [THR_W-1:0] RST_REPEAT     = 16'd200;

endpackage

[rtl/kdlp_cfg.sv]
// ----------------------------------------------------------------------------
// kdlp_cfg
// Configuration register file: polarity and the three tick thresholds.
// ----------------------------------------------------------------------------
module kdlp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kdlp_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [kdlp_pkg::CFG_W-1:0]  i_cfg_data,
    output kdlp_pkg::t_cfg              o_cfg
);
    import kdlp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ACTIVE_LOW: n_cfg.active_low       = i_cfg_data[0];
                REG_DEBOUNCE:   n_cfg.debounce_ticks   = i_cfg_data[THR_W-1:0];
                REG_LONG_PRESS: n_cfg.long_press_ticks = i_cfg_data[THR_W-1:0];
                REG_REPEAT:     n_cfg.repeat_ticks     = i_cfg_data[THR_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low       <= 1'b0;
            r_cfg.debounce_ticks   <= RST_DEBOUNCE;
            r_cfg.long_press_ticks <= RST_LONG_PRESS;
            r_cfg.repeat_ticks     <= RST_REPEAT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/kdlp_step.sv]
// ----------------------------------------------------------------------------
// kdlp_step
// Next-state logic of the key state machine for one scan: one wrapping
// subtract and one compare against the threshold of the current phase.
// ----------------------------------------------------------------------------
module kdlp_step #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  kdlp_pkg::t_cfg              i_cfg,
    input  kdlp_pkg::t_phase            i_phase,
    input  logic [TICK_WIDTH-1:0]       i_mark,
    input  logic                        i_pin_level,
    input  logic [TICK_WIDTH-1:0]       i_now,
    output kdlp_pkg::t_phase            o_phase,
    output logic [TICK_WIDTH-1:0]       o_mark,
    output logic                        o_pressed_event,
    output logic                        o_long_event
);
    import kdlp_pkg::*;

    logic                  active;
    logic [TICK_WIDTH-1:0] diff;
    logic [THR_W-1:0]      thr;
    logic [TICK_WIDTH-1:0] thr_ext;
    logic                  reach;

    assign active  = i_pin_level ^ i_cfg.active_low;
    assign diff    = i_now - i_mark;

    always_comb begin
        unique case (i_phase)
            PH_DEBOUNCE: thr = i_cfg.debounce_ticks;
            PH_PRESSED:  thr = i_cfg.long_press_ticks;
            default:     thr = i_cfg.repeat_ticks;
        endcase
    end

    assign thr_ext = {{(TICK_WIDTH-THR_W){1'b0}}, thr};

    // Debounce needs a strictly longer hold; long and repeat fire on equality.
    assign reach = (i_phase == PH_DEBOUNCE) ? (diff > thr_ext) : (diff >= thr_ext);

    always_comb begin
        o_phase         = i_phase;
        o_mark          = i_mark;
        o_pressed_event = 1'b0;
        o_long_event    = 1'b0;
        unique case (i_phase)
            PH_IDLE: begin
                if (active) begin
                    o_phase = PH_DEBOUNCE;
                    o_mark  = i_now;
                end
            end
            PH_DEBOUNCE: begin
                if (!active) begin
                    o_phase = PH_IDLE;
                end else if (reach) begin
                    o_phase         = PH_PRESSED;
                    o_mark          = i_now;
                    o_pressed_event = 1'b1;
                end
            end
            PH_PRESSED: begin
                if (!active) begin
                    o_phase = PH_IDLE;
                end else if (reach) begin
                    o_phase      = PH_LONG;
                    o_mark       = i_now;
                    o_long_event = 1'b1;
                end
            end
            default: begin
                if (!active) begin
                    o_phase = PH_IDLE;
                end else if (reach) begin
                    o_mark       = i_now;
                    o_long_event = 1'b1;
                end
            end
        endcase
    end

endmodule

[rtl/key_debounce_longpress_fsm_unit.sv]
// ----------------------------------------------------------------------------
// key_debounce_longpress_fsm_unit
// An accepted scan beat passes the input register, then the result register.
// Throughput: one scan per cycle unless stalled. The input register feeds the
// state machine and result register; the state updates as a beat enters the
// result. Reset (synchronous, active low): phase idle, time stamp zero,
// registers at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module key_debounce_longpress_fsm_unit #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kdlp_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [kdlp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_pin_level,
    input  logic [kdlp_pkg::NOW_W-1:0]  i_now_tick,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_pressed_event,
    output logic                        o_long_event,
    output logic [1:0]                  o_key_phase
);
    import kdlp_pkg::*;

    t_cfg cfg;

    // Input stage.
    logic                  r_s1_valid;
    logic                  r_s1_pin;
    logic [TICK_WIDTH-1:0] r_s1_now;
    logic [TICK_WIDTH-1:0] now_w;

    // Machine state.
    t_phase                r_phase;
    logic [TICK_WIDTH-1:0] r_mark;
    t_phase                n_phase;
    logic [TICK_WIDTH-1:0] n_mark;
    logic                  n_pressed;
    logic                  n_long;

    // Result stage.
    logic                  r_out_valid;
    logic                  r_pressed;
    logic                  r_long;
    t_phase                r_out_phase;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // The tick is taken modulo 2^TICK_WIDTH.
    generate
        if (TICK_WIDTH >= NOW_W) begin : g_now_ext
            assign now_w = {{(TICK_WIDTH-NOW_W){1'b0}}, i_now_tick};
        end else begin : g_now_trunc
            assign now_w = i_now_tick[TICK_WIDTH-1:0];
        end
    endgenerate

    kdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kdlp_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .i_cfg           (cfg),
        .i_phase         (r_phase),
        .i_mark          (r_mark),
        .i_pin_level     (r_s1_pin),
        .i_now           (r_s1_now),
        .o_phase         (n_phase),
        .o_mark          (n_mark),
        .o_pressed_event (n_pressed),
        .o_long_event    (n_long)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_pin <= i_pin_level;
            r_s1_now <= now_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mark  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_mark  <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pressed   <= n_pressed;
            r_long      <= n_long;
            r_out_phase <= n_phase;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pressed_event = r_pressed;
    assign o_long_event    = r_long;
    assign o_key_phase     = r_out_phase;

endmodule
